// File: hdl/jmh_pkg.sv
// Shared constants, types and helper functions for the Jenkins/murmur3 hash core.
// No dependencies; used by the front end, task queue, back end and top level.
package jmh_pkg;

    localparam logic [31:0] MM_SEED = 32'h5c0940e9;
    localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2   = 32'h1b873593;
    localparam logic [31:0] MM_ADD  = 32'he6546b64;
    localparam logic [31:0] MM_F1   = 32'h85ebca6b;
    localparam logic [31:0] MM_F2   = 32'hc2b2ae35;

    localparam int QUEUE_DEPTH = 2;

    // One unit of murmur work handed from the front end to the back end.
    typedef struct packed {
        logic        has_word; // a full 32-bit word is ready to mix
        logic [31:0] word;
        logic        last;     // finalize after the word (if any)
        logic [23:0] tail;     // leftover bytes, little-endian
        logic [31:0] count;    // message length mod 2^32
        logic [31:0] jacc;     // Jenkins accumulator before finalization
    } t_task;

    // Back end status seen by the top level.
    typedef struct packed {
        logic busy;
        logic finish;  // result register is written this cycle
    } t_back_stat;

    function automatic logic [31:0] rotl32(input logic [31:0] a, input int s);
        rotl32 = (a << s) | (a >> (32 - s));
    endfunction

    function automatic logic [31:0] jenkins_step(input logic [31:0] acc,
                                                 input logic [7:0]  b);
        logic [31:0] h;
        h = acc + {24'd0, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        jenkins_step = h;
    endfunction

    function automatic logic [31:0] jenkins_final(input logic [31:0] acc);
        logic [31:0] j;
        j = acc + (acc << 3);
        j = j ^ (j >> 11);
        j = j + (j << 15);
        jenkins_final = j;
    endfunction

endpackage

// File: hdl/jmh_front.sv
// Front end: accepts message bytes, runs the Jenkins step, packs murmur words.
// Depends on jmh_pkg; emits one t_task per completed word or message end.
module jmh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_data_byte,
    input  logic           i_byte_present,
    input  logic           i_last,
    output logic           o_task_push,
    output jmh_pkg::t_task o_task
);

    logic [31:0] r_jacc, n_jacc;
    logic [23:0] r_wbytes, n_wbytes;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic        has_word;
    logic [31:0] word;

    always_comb begin
        n_jacc   = r_jacc;
        n_wbytes = r_wbytes;
        n_phase  = r_phase;
        n_count  = r_count;
        has_word = 1'b0;
        word     = {i_data_byte, r_wbytes};
        if (i_byte_present) begin
            n_jacc  = jmh_pkg::jenkins_step(r_jacc, i_data_byte);
            n_count = r_count + 32'd1;
            n_phase = r_phase + 2'd1;
            unique case (r_phase)
                2'd0: n_wbytes = {r_wbytes[23:8], i_data_byte};
                2'd1: n_wbytes = {r_wbytes[23:16], i_data_byte, r_wbytes[7:0]};
                2'd2: n_wbytes = {i_data_byte, r_wbytes[15:0]};
                default: begin
                    has_word = 1'b1;
                    n_wbytes = 24'd0;
                end
            endcase
        end
    end

    assign o_task_push   = i_fire && (has_word || i_last);
    assign o_task.has_word = has_word;
    assign o_task.word     = word;
    assign o_task.last     = i_last;
    assign o_task.tail     = n_wbytes;
    assign o_task.count    = n_count;
    assign o_task.jacc     = n_jacc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_jacc   <= '0;
            r_wbytes <= '0;
            r_phase  <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_jacc   <= n_jacc;
            r_wbytes <= n_wbytes;
            r_phase  <= n_phase;
            r_count  <= n_count;
        end
    end

endmodule

// File: hdl/jmh_queue.sv
// Short task queue between front end and back end.
// Depends on jmh_pkg for t_task; depth set by parameter P_DEPTH (at least 2).
module jmh_queue #(
    parameter int P_DEPTH = jmh_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jmh_pkg::t_task i_task,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output jmh_pkg::t_task o_head
);

    localparam int IW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    jmh_pkg::t_task r_mem [P_DEPTH];
    logic [IW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IW'(P_DEPTH - 1)) ? '0 : r_wr + IW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == IW'(P_DEPTH - 1)) ? '0 : r_rd + IW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hdl/jmh_back.sv
// Back end: murmur3 word mixing and finalization on one shared 32x32 multiplier.
// Depends on jmh_pkg; owns the result register shown on the output queue ports.
module jmh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  jmh_pkg::t_task      i_q_head,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [63:0]         o_hash,
    output jmh_pkg::t_back_stat o_stat
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_C2   = 6'b000010,
        S_MIX  = 6'b000100,
        S_FIN  = 6'b001000,
        S_F2   = 6'b010000,
        S_F3   = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    jmh_pkg::t_task r_task, n_task;
    logic [31:0]    r_k, n_k;
    logic [31:0]    r_m, n_m;
    logic [31:0]    r_j, n_j;
    logic           r_word, n_word;
    logic           r_out_valid, n_out_valid;
    logic [63:0]    r_out_hash, n_out_hash;
    logic [31:0]    mul_a, mul_b, prod;
    logic [31:0]    mix, fin0, fin1;
    logic           out_pop, finish;

    assign prod    = mul_a * mul_b;
    assign out_pop = r_out_valid && i_pop;

    always_comb begin
        n_state     = r_state;
        n_task      = r_task;
        n_k         = r_k;
        n_m         = r_m;
        n_j         = r_j;
        n_word      = r_word;
        n_out_valid = r_out_valid && !i_pop;
        n_out_hash  = r_out_hash;
        mul_a       = r_k;
        mul_b       = jmh_pkg::MM_C1;
        o_q_pop     = 1'b0;
        finish      = 1'b0;
        mix         = jmh_pkg::rotl32(r_m ^ r_k, 13);
        fin0        = r_m ^ r_k ^ r_task.count;
        fin1        = fin0 ^ (fin0 >> 16);
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_task  = i_q_head;
                    mul_a   = i_q_head.has_word ? i_q_head.word : {8'd0, i_q_head.tail};
                    n_k     = prod;
                    n_word  = i_q_head.has_word;
                    n_state = S_C2;
                end
            end
            S_C2: begin
                mul_a   = jmh_pkg::rotl32(r_k, 15);
                mul_b   = jmh_pkg::MM_C2;
                n_k     = prod;
                n_state = r_word ? S_MIX : S_FIN;
            end
            S_MIX: begin
                // m * 5 + ADD as shift-add
                n_m = mix + {mix[29:0], 2'b00} + jmh_pkg::MM_ADD;
                if (r_task.last) begin
                    mul_a   = {8'd0, r_task.tail};
                    n_k     = prod;
                    n_word  = 1'b0;
                    n_state = S_C2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                mul_a   = fin1;
                mul_b   = jmh_pkg::MM_F1;
                n_k     = prod;
                n_j     = jmh_pkg::jenkins_final(r_task.jacc);
                n_state = S_F2;
            end
            S_F2: begin
                mul_a   = r_k ^ (r_k >> 13);
                mul_b   = jmh_pkg::MM_F2;
                n_k     = prod;
                n_state = S_F3;
            end
            S_F3: begin
                // hold until the result register is free
                if (!r_out_valid || out_pop) begin
                    finish      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_hash  = {r_j, r_k ^ (r_k >> 16)};
                    n_m         = jmh_pkg::MM_SEED;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= jmh_pkg::MM_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_m         <= n_m;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task     <= n_task;
        r_k        <= n_k;
        r_j        <= n_j;
        r_word     <= n_word;
        r_out_hash <= n_out_hash;
    end

    assign o_empty       = !r_out_valid;
    assign o_hash        = r_out_hash;
    assign o_stat.busy   = (r_state != S_IDLE);
    assign o_stat.finish = finish;

endmodule

// File: hdl/jenkins_murmur3_64_hash_core.sv
// Jenkins one-at-a-time (bits 63..32) and murmur3 x86_32 (bits 31..0) message hash.
// Takes one byte per cycle while the queue is not full; the back end runs each
// 4-byte word through S_IDLE, S_C2 and S_MIX. A message end runs S_IDLE, S_C2,
// S_FIN, S_F2 and S_F3; S_MIX and a second S_C2 come before S_FIN if it ends a word.
// Reset is synchronous, active low: clears accumulators, task queue, sequencer, result.
module jenkins_murmur3_64_hash_core #(
    parameter int P_QUEUE_DEPTH = jmh_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side: queue-style push/full
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    // result side: queue-style empty/pop
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_hash
);

    // Front end runs the cheap Jenkins step and word packing at byte rate. Every
    // completed word, and every message end, becomes one task in a short queue.
    // The back end drains tasks through a small sequencer around a single
    // combinational 32x32 multiplier. An input transfer is taken whenever the queue
    // has room, even while a finished hash waits in the result register.

    logic                q_push, q_pop, q_full, q_empty;
    jmh_pkg::t_task      q_in, q_head;
    jmh_pkg::t_back_stat back_stat;
    logic                fire;

    assign full = q_full;
    assign fire = push && !q_full;

    jmh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_task_push    (q_push),
        .o_task         (q_in)
    );

    jmh_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    jmh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_hash    (o_hash),
        .o_stat    (back_stat)
    );

    // Never write a task into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("task queue overflow");

    // Never take a task from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("task queue underflow");

    // A result appears only after the back end finished a message.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(back_stat.finish))
        else $error("result register written outside finalization");

    // The sequencer is working whenever it pulls a task.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> back_stat.busy)
        else $error("task popped without starting work");

endmodule

// File: tb/sv/message_hash_tracker_pkg.sv
// Expected-hash tracker for the Jenkins/murmur3 64-bit message hash core.
// Holds its own copy of the hash state and a queue of pending results.
// No dependencies; compiled ahead of tb_jenkins_murmur3_64_hash_core.
package message_hash_tracker_pkg;

    class message_hash_tracker;
        localparam bit [31:0] SEED    = 32'h5c0940e9;
        localparam bit [31:0] MIX_C1  = 32'hcc9e2d51;
        localparam bit [31:0] MIX_C2  = 32'h1b873593;
        localparam bit [31:0] MIX_ADD = 32'he6546b64;
        localparam bit [31:0] FMIX_1  = 32'h85ebca6b;
        localparam bit [31:0] FMIX_2  = 32'hc2b2ae35;

        bit [31:0]   jenkins_sum;
        bit [31:0]   murmur_sum;
        bit [23:0]   partial_word;
        bit [1:0]    partial_len;
        bit [31:0]   message_len;
        bit [63:0]   expected_hashes[$];
        int unsigned error_count;
        int unsigned hashes_checked;

        function new();
            clear_state();
            error_count    = 0;
            hashes_checked = 0;
        endfunction

        function void clear_state();
            jenkins_sum  = '0;
            murmur_sum   = SEED;
            partial_word = '0;
            partial_len  = '0;
            message_len  = '0;
        endfunction

        function bit [31:0] rotate_left(bit [31:0] a, int unsigned s);
            bit [63:0] doubled;
            doubled = {a, a} << s;
            return doubled[63:32];
        endfunction

        function bit [31:0] scramble_word(bit [31:0] k);
            bit [31:0] t;
            t = k * MIX_C1;
            t = rotate_left(t, 15);
            return t * MIX_C2;
        endfunction

        // Update the running state for one accepted transfer; queue a hash on last.
        function void absorb_transfer(bit [7:0] data, bit present, bit last);
            bit [31:0] h;
            bit [31:0] m;
            bit [31:0] j;
            if (present) begin
                h = jenkins_sum + {24'd0, data};
                h = h + (h << 10);
                h = h ^ (h >> 6);
                jenkins_sum = h;
                if (partial_len == 2'd3) begin
                    m = murmur_sum ^ scramble_word({data, partial_word});
                    m = rotate_left(m, 13);
                    murmur_sum   = m * 32'd5 + MIX_ADD;
                    partial_word = '0;
                    partial_len  = '0;
                end else begin
                    partial_word = partial_word | ({16'd0, data} << (8 * partial_len));
                    partial_len  = partial_len + 2'd1;
                end
                message_len = message_len + 32'd1;
            end
            if (last) begin
                j = jenkins_sum;
                j = j + (j << 3);
                j = j ^ (j >> 11);
                j = j + (j << 15);
                m = murmur_sum ^ scramble_word({8'd0, partial_word}) ^ message_len;
                m = m ^ (m >> 16);
                m = m * FMIX_1;
                m = m ^ (m >> 13);
                m = m * FMIX_2;
                m = m ^ (m >> 16);
                expected_hashes.push_back({j, m});
                clear_state();
            end
        endfunction

        function void compare_hash(bit [63:0] actual);
            bit [63:0] want;
            if (expected_hashes.size() == 0) begin
                $error("hash: result with no message pending, actual %h", actual);
                error_count++;
                return;
            end
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (actual !== want) begin
                $error("hash: expected %h, actual %h", want, actual);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_hashes.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_jenkins_murmur3_64_hash_core.sv
// Self-checking testbench for jenkins_murmur3_64_hash_core: directed and random messages.
// Depends on jmh_pkg (via the core) and message_hash_tracker_pkg for expected hashes.
module tb_jenkins_murmur3_64_hash_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 300_000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the core
    localparam int DRAIN_CYCLES   = 40;    // quiet time after the last hash to catch stray results

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_byte_present = 1'b0;
    logic        i_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_hash;

    jenkins_murmur3_64_hash_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_hash         (o_hash)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    message_hash_tracker_pkg::message_hash_tracker hashes = new();

    // Idle rates in percent, changed by the stimulus between phases.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    bit          long_hold_armed   = 1'b0;

    // Run statistics for the summary.
    int unsigned byte_transfers  = 0;
    int unsigned idle_transfers  = 0;
    int unsigned messages_sent   = 0;
    int unsigned longest_message = 0;
    int unsigned full_stalls     = 0;

    // Offer one item and hold it until the core takes it. Push stays high
    // across back-to-back transfers; it only drops during sender idle cycles.
    task automatic offer_item(input logic [7:0] data, input logic present, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            push           <= 1'b0;
            i_data_byte    <= 8'($urandom_range(0, 255));
            i_byte_present <= 1'($urandom_range(0, 1));
            i_last         <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= data;
        i_byte_present <= present;
        i_last         <= last;
        @(posedge i_clk);
        // full as sampled here is its value at this edge: the transfer waits on it
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        hashes.absorb_transfer(data, present, last);
        if (present)
            byte_transfers++;
        else if (!last)
            idle_transfers++;
    endtask

    // Send one well-formed message of len bytes. Either the final byte carries
    // last, or a byteless end item with junk data closes it.
    task automatic send_message(input int unsigned len, input bit end_on_byte,
                                input int unsigned noise_pct);
        bit close_on_byte;
        close_on_byte = end_on_byte && (len != 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            offer_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte)
            offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_sent++;
        if (len > longest_message)
            longest_message = len;
    endtask

    // Receiver: check the result at each edge that completes a transfer,
    // then choose pop for the next cycle. A long hold-off runs once when armed.
    initial begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                hashes.compare_hash(o_hash);
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (long_hold_armed && !hold_done) begin
                hold_left = LONG_HOLD - 1;
                hold_done = 1'b1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Hard limit: the slowest correct run ends far sooner.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout: %0d hashes still expected", hashes.pending());
        $display("jenkins_murmur3_64_hash_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned item_goal;
        int unsigned roll;
        int unsigned len;

        // Hold reset low, then release it on an edge.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, one-byte extremes, ignored idle item,
        // byteless ends after 2 and 3 byte tails, full words closing on a byte.
        offer_item(8'h5a, 1'b0, 1'b1);
        offer_item(8'h00, 1'b1, 1'b1);
        offer_item(8'hff, 1'b1, 1'b1);
        offer_item(8'ha5, 1'b0, 1'b0);
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'h63, 1'b1, 1'b0);
        offer_item(8'hff, 1'b0, 1'b1);
        offer_item(8'h80, 1'b1, 1'b0);
        offer_item(8'h01, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 4; i++)
            offer_item(8'hff, 1'b1, i == 3);
        for (int i = 0; i < 5; i++)
            offer_item(8'(i), 1'b1, i == 4);
        messages_sent += 7;

        // Random: three idle profiles, one third of the items each.
        // Arm the long receiver hold-off as the first phase starts.
        long_hold_armed = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 18;
                    receiver_idle_pct = 45;
                end
                1: begin
                    sender_idle_pct   = 45;
                    receiver_idle_pct = 18;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            item_goal = byte_transfers + messages_sent + RANDOM_ITEMS / 3;
            while (byte_transfers + messages_sent < item_goal) begin
                // Mostly short messages so every tail length recurs often.
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    len = $urandom_range(0, 7);
                else if (roll < 95)
                    len = $urandom_range(8, 24);
                else
                    len = $urandom_range(25, 64);
                send_message(len, 1'($urandom_range(0, 1)),
                             $urandom_range(0, 1) ? 10 : 0);
            end
        end

        // Drop push and drain: wait for every hash, then watch for strays.
        push <= 1'b0;
        while (hashes.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages (%0d bytes, longest %0d) and %0d idle items",
                 messages_sent, byte_transfers, longest_message, idle_transfers);
        $display("checked %0d hashes; input held off by full for %0d cycles",
                 hashes.hashes_checked, full_stalls);
        if (hashes.error_count == 0)
            $display("jenkins_murmur3_64_hash_core verification clean");
        else
            $display("jenkins_murmur3_64_hash_core verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/jmh_pkg.sv
hdl/jmh_front.sv
hdl/jmh_queue.sv
hdl/jmh_back.sv
hdl/jenkins_murmur3_64_hash_core.sv
tb/sv/message_hash_tracker_pkg.sv
tb/sv/tb_jenkins_murmur3_64_hash_core.sv
